### hdl/u8u16_pkg.sv
// shared types, constants and helpers for the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps
`default_nettype none
package u8u16_pkg;

	localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
	localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
	localparam logic [7:0]  LEAD3_E0    = 8'hE0;
	localparam logic [7:0]  LEAD3_ED    = 8'hED;
	localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
	localparam logic [7:0]  LEAD4_F0    = 8'hF0;
	localparam logic [7:0]  LEAD4_F4    = 8'hF4;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam int          FIFO_DEPTH  = 4;
	localparam int          PTR_W       = $clog2(FIFO_DEPTH);

	// allowed range of the second byte of a sequence
	typedef enum logic [2:0] {
		CLS_ANY  = 3'd0, // 80..bf
		CLS_E0   = 3'd1, // a0..bf
		CLS_ED   = 3'd2, // 80..9f
		CLS_F0   = 3'd3, // 90..bf
		CLS_F4   = 3'd4  // 80..8f
	} second_cls_t;

	typedef struct packed {
		logic [15:0] unit_count;
		logic [15:0] unit;
		logic        is_error;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic logic second_ok(input logic [2:0] cls, input logic [7:0] b);
		case (cls)
			CLS_ANY: second_ok = (b >= 8'h80) && (b <= 8'hBF);
			CLS_E0:  second_ok = (b >= 8'hA0) && (b <= 8'hBF);
			CLS_ED:  second_ok = (b >= 8'h80) && (b <= 8'h9F);
			CLS_F0:  second_ok = (b >= 8'h90) && (b <= 8'hBF);
			CLS_F4:  second_ok = (b >= 8'h80) && (b <= 8'h8F);
			default: second_ok = 1'b0;
		endcase
	endfunction

endpackage
`default_nettype wire

### hdl/u8u16_decode.sv
// per-string decode state and single-pass byte decode
`timescale 1ns / 1ps
`default_nettype none
module u8u16_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [7:0]        byte_in,
	input  wire logic              is_final,
	output u8u16_pkg::step_t       step
);
	import u8u16_pkg::*;

	logic [1:0]  pend_q;
	logic [20:0] acc_q;
	logic [2:0]  cls_q;
	logic        at2_q;
	logic        fault_q;
	logic [15:0] units_q;

	logic [1:0]  pend_n;
	logic [20:0] acc_n;
	logic [2:0]  cls_n;
	logic        at2_n;
	logic        fault_n;
	logic [15:0] units_n;
	logic [15:0] cnt1;
	logic [15:0] cnt2;

	assign cnt1 = sat_inc(units_q);
	assign cnt2 = sat_inc(cnt1);

	always_comb begin
		logic        ok;
		logic [20:0] asm_cp;
		logic [19:0] v;
		ok     = 1'b0;
		asm_cp = '0;
		v      = '0;
		pend_n  = pend_q;
		acc_n   = acc_q;
		cls_n   = cls_q;
		at2_n   = at2_q;
		fault_n = fault_q;
		step    = '0;
		step.r0.unit_count = cnt1;
		step.r1.unit_count = cnt2;
		if (!fault_q) begin
			if (pend_q == 2'd0) begin
				if (!byte_in[7]) begin
					step.n = 2'd1;
					step.r0.unit = {8'd0, byte_in};
				end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
					pend_n = 2'd1; acc_n = {16'd0, byte_in[4:0]}; cls_n = CLS_ANY; at2_n = 1'b1;
				end else if (byte_in == LEAD3_E0) begin
					pend_n = 2'd2; acc_n = {17'd0, byte_in[3:0]}; cls_n = CLS_E0; at2_n = 1'b1;
				end else if (byte_in == LEAD3_ED) begin
					pend_n = 2'd2; acc_n = {17'd0, byte_in[3:0]}; cls_n = CLS_ED; at2_n = 1'b1;
				end else if (byte_in > LEAD3_E0 && byte_in <= LEAD3_MAX) begin
					pend_n = 2'd2; acc_n = {17'd0, byte_in[3:0]}; cls_n = CLS_ANY; at2_n = 1'b1;
				end else if (byte_in == LEAD4_F0) begin
					pend_n = 2'd3; acc_n = {18'd0, byte_in[2:0]}; cls_n = CLS_F0; at2_n = 1'b1;
				end else if (byte_in > LEAD4_F0 && byte_in < LEAD4_F4) begin
					pend_n = 2'd3; acc_n = {18'd0, byte_in[2:0]}; cls_n = CLS_ANY; at2_n = 1'b1;
				end else if (byte_in == LEAD4_F4) begin
					pend_n = 2'd3; acc_n = {18'd0, byte_in[2:0]}; cls_n = CLS_F4; at2_n = 1'b1;
				end else begin
					fault_n = 1'b1;
				end
			end else begin
				ok = at2_q ? second_ok(cls_q, byte_in) : (byte_in[7:6] == 2'b10);
				if (!ok) begin
					fault_n = 1'b1;
				end else begin
					asm_cp = {acc_q[14:0], byte_in[5:0]};
					acc_n  = asm_cp;
					at2_n  = 1'b0;
					pend_n = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						acc_n = '0;
						if (asm_cp[20:16] == 5'd0) begin
							step.n = 2'd1;
							step.r0.unit = asm_cp[15:0];
						end else begin
							v = 20'(asm_cp - SUPP_BASE);
							step.n = 2'd2;
							step.r0.unit = HI_SURR + {6'd0, v[19:10]};
							step.r1.unit = LO_SURR + {6'd0, v[9:0]};
						end
					end
				end
			end
		end
		unique case (step.n)
			2'd1:    units_n = cnt1;
			2'd2:    units_n = cnt2;
			default: units_n = units_q;
		endcase
		if (is_final) begin
			if (fault_n || pend_n != 2'd0) begin
				// faulted or truncated string: one error word replaces everything
				step = '0;
				step.n = 2'd1;
				step.r0.is_error   = 1'b1;
				step.r0.last       = 1'b1;
				step.r0.unit_count = units_n;
			end else if (step.n == 2'd2) begin
				step.r1.last = 1'b1;
			end else if (step.n == 2'd1) begin
				step.r0.last = 1'b1;
			end
			pend_n  = '0;
			acc_n   = '0;
			cls_n   = '0;
			at2_n   = 1'b0;
			fault_n = 1'b0;
			units_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			acc_q   <= '0;
			cls_q   <= '0;
			at2_q   <= 1'b0;
			fault_q <= 1'b0;
			units_q <= '0;
		end else if (en) begin
			pend_q  <= pend_n;
			acc_q   <= acc_n;
			cls_q   <= cls_n;
			at2_q   <= at2_n;
			fault_q <= fault_n;
			units_q <= units_n;
		end
	end

endmodule
`default_nettype wire

### hdl/u8u16_fifo.sv
// small result queue taking up to two words per cycle and giving one
`timescale 1ns / 1ps
`default_nettype none
module u8u16_fifo (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire u8u16_pkg::step_t                  push,
	input  wire logic                              pop,
	output u8u16_pkg::result_t                     head,
	output logic                                   not_empty,
	output logic                                   room2
);
	import u8u16_pkg::*;

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     count_q;
	logic               do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];
	// room for a surrogate pair regardless of the pop this cycle
	assign room2     = (count_q <= (PTR_W+1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(do_pop);
			count_q <= count_q + (PTR_W+1)'(push.n) - (PTR_W+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

### hdl/utf8_to_utf16_transcoder.sv
// top level: strict utf-8 byte stream in, utf-16 code unit stream out
//
//  channel  dir  payload                                   end marker
//  s_axis   in   tdata[7:0] byte_in                        tlast is_final
//  m_axis   out  tdata[15:0] unit, tdata[31:16] unit_count tlast last, tuser is_error
//
// one byte per cycle is accepted; each byte is held in the input register, and its words
// are then registered in the result queue. a supplementary code point puts
// two words in the queue, which drains one word a cycle, so the input only
// pauses when the queue lacks room for a pair. reset clears all string state
// and empties the queue. output stalls back up through the queue to tready
//
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [15:0] unit, [31:16] unit_count
	output logic             m_axis_tlast,
	output logic             m_axis_tuser    // [0] is_error
);
	import u8u16_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        final_s1;
	logic        adv;
	logic        room2;
	step_t       step;
	step_t       push;
	result_t     head;

	assign adv           = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
		end
	end

	u8u16_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.byte_in  (byte_s1),
		.is_final (final_s1),
		.step     (step)
	);

	always_comb begin
		push = step;
		if (!adv) begin
			push.n = 2'd0;
		end
	end

	u8u16_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_axis_tready),
		.head      (head),
		.not_empty (m_axis_tvalid),
		.room2     (room2)
	);

	assign m_axis_tdata = {head.unit_count, head.unit};
	assign m_axis_tlast = head.last;
	assign m_axis_tuser = head.is_error;

endmodule
`default_nettype wire

### bench/tb_top.sv
// testbench for the utf-8 to utf-16 transcoder: directed and random byte strings checked word by word
`timescale 1ns / 1ps
module tb_top;
	import u8u16_pkg::*;

	localparam int WDOG_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 1500;
	localparam int TAIL_BYTES   = 120;
	localparam int HOLD_CYCLES  = 48;
	localparam int MAX_PRINT    = 20;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		result_t    want;
	} stim_row_t;

	// result fields in order: unit_count, unit, is_error, last
	localparam result_t NONE         = '0;
	localparam result_t ERR_NO_UNITS = '{16'd0, 16'h0000, 1'b1, 1'b1};

	localparam stim_row_t DIR_ROWS [26] = '{
		'{8'h41, 1'b1, 1'b1, '{16'd1, 16'h0041, 1'b0, 1'b1}},
		'{8'h00, 1'b0, 1'b0, NONE},	// null byte is an ordinary character
		'{8'h7F, 1'b1, 1'b1, '{16'd2, 16'h007F, 1'b0, 1'b1}},
		'{8'hC2, 1'b0, 1'b0, NONE},
		'{8'h80, 1'b0, 1'b0, NONE},
		'{8'hDF, 1'b0, 1'b0, NONE},
		'{8'hBF, 1'b1, 1'b0, NONE},
		'{8'hC1, 1'b1, 1'b1, ERR_NO_UNITS},	// overlong lead
		'{8'hF0, 1'b0, 1'b0, NONE},	// lowest supplementary, pair on the final byte
		'{8'h90, 1'b0, 1'b0, NONE},
		'{8'h80, 1'b0, 1'b0, NONE},
		'{8'h80, 1'b1, 1'b0, NONE},
		'{8'hF4, 1'b0, 1'b0, NONE},	// highest code point
		'{8'h8F, 1'b0, 1'b0, NONE},
		'{8'hBF, 1'b0, 1'b0, NONE},
		'{8'hBF, 1'b0, 1'b0, NONE},
		'{8'hED, 1'b0, 1'b0, NONE},	// surrogate code point
		'{8'hA0, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b0, 1'b0, NONE},	// ignored once faulted
		'{8'h41, 1'b1, 1'b0, NONE},
		'{8'hE0, 1'b0, 1'b0, NONE},	// overlong three-byte form
		'{8'h9F, 1'b1, 1'b1, ERR_NO_UNITS},
		'{8'hE1, 1'b0, 1'b0, NONE},	// truncated sequence
		'{8'h80, 1'b1, 1'b1, ERR_NO_UNITS},
		'{8'h80, 1'b0, 1'b0, NONE},	// stray continuation
		'{8'hF5, 1'b1, 1'b1, ERR_NO_UNITS}
	};

	localparam logic [20:0] CP_EDGES [10] = '{
		21'h00000, 21'h0007F, 21'h00080, 21'h007FF, 21'h00800,
		21'h0D7FF, 21'h0E000, 21'h0FFFF, 21'h10000, 21'h10FFFF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	// decoder state mirrored by the testbench
	logic [1:0]  seq_left = '0;
	logic [20:0] cp_acc = '0;
	second_cls_t sec_cls = CLS_ANY;
	logic        at_second = 1'b0;
	logic        faulted = 1'b0;
	logic [15:0] units_out = '0;

	result_t     utf16_due [$];
	logic [7:0]  str_bytes [$];
	int          mismatches = 0;
	int          live_bytes = 0;
	int          quiet_cycles = 0;
	logic        idle_on = 1'b0;
	logic        hold_req = 1'b0;

	utf8_to_utf16_transcoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic result_t next_unit(input logic [15:0] u);
		if (units_out != COUNT_MAX)
			units_out = units_out + 16'd1;
		return '{units_out, u, 1'b0, 1'b0};
	endfunction

	function automatic void open_seq(input logic [1:0] left, input logic [20:0] bits,
			input second_cls_t cls);
		seq_left = left;
		cp_acc = bits;
		sec_cls = cls;
		at_second = 1'b1;
	endfunction

	function automatic void transcode_byte(input logic [7:0] b, input logic fin,
			output result_t r [2], output int n);
		logic        ok;
		logic [19:0] v;
		r[0] = '0;
		r[1] = '0;
		n = 0;
		if (!faulted) begin
			if (seq_left == 2'd0) begin
				if (b < 8'h80) begin
					r[0] = next_unit({8'h00, b});
					n = 1;
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					open_seq(2'd1, {16'd0, b[4:0]}, CLS_ANY);
				end else if (b == LEAD3_E0) begin
					open_seq(2'd2, {17'd0, b[3:0]}, CLS_E0);
				end else if (b == LEAD3_ED) begin
					open_seq(2'd2, {17'd0, b[3:0]}, CLS_ED);
				end else if (b > LEAD3_E0 && b <= LEAD3_MAX) begin
					open_seq(2'd2, {17'd0, b[3:0]}, CLS_ANY);
				end else if (b == LEAD4_F0) begin
					open_seq(2'd3, {18'd0, b[2:0]}, CLS_F0);
				end else if (b > LEAD4_F0 && b < LEAD4_F4) begin
					open_seq(2'd3, {18'd0, b[2:0]}, CLS_ANY);
				end else if (b == LEAD4_F4) begin
					open_seq(2'd3, {18'd0, b[2:0]}, CLS_F4);
				end else begin
					faulted = 1'b1;
				end
			end else begin
				if (at_second) begin
					case (sec_cls)
						CLS_E0:  ok = b >= 8'hA0 && b <= 8'hBF;
						CLS_ED:  ok = b >= 8'h80 && b <= 8'h9F;
						CLS_F0:  ok = b >= 8'h90 && b <= 8'hBF;
						CLS_F4:  ok = b >= 8'h80 && b <= 8'h8F;
						default: ok = b >= 8'h80 && b <= 8'hBF;
					endcase
				end else begin
					ok = b[7:6] == 2'b10;
				end
				if (!ok) begin
					faulted = 1'b1;
				end else begin
					cp_acc = {cp_acc[14:0], b[5:0]};
					at_second = 1'b0;
					seq_left = seq_left - 2'd1;
					if (seq_left == 2'd0) begin
						if (cp_acc <= 21'h00FFFF) begin
							r[0] = next_unit(cp_acc[15:0]);
							n = 1;
						end else begin
							v = 20'(cp_acc - SUPP_BASE);
							r[0] = next_unit(HI_SURR + {6'd0, v[19:10]});
							r[1] = next_unit(LO_SURR + {6'd0, v[9:0]});
							n = 2;
						end
						cp_acc = '0;
					end
				end
			end
		end
		if (fin) begin
			// a faulted or unfinished string ends in a single error word
			if (faulted || seq_left != 2'd0) begin
				r[0] = '{units_out, 16'h0000, 1'b1, 1'b1};
				n = 1;
			end else if (n > 0) begin
				r[n - 1].last = 1'b1;
			end
			seq_left = '0;
			cp_acc = '0;
			sec_cls = CLS_ANY;
			at_second = 1'b0;
			faulted = 1'b0;
			units_out = '0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed = 1'b0,
			input result_t want = '0);
		result_t r [2];
		int      n;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		if (!faulted || fin)
			live_bytes++;
		transcode_byte(b, fin, r, n);
		if (typed)
			utf16_due.push_back(want);
		else
			for (int i = 0; i < n; i++)
				utf16_due.push_back(r[i]);
	endtask

	function automatic void put_cp(input logic [20:0] cp, input int len);
		case (len)
			1: str_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic logic [20:0] pick_cp();
		logic [20:0] cp;
		case ($urandom_range(0, 5))
			0, 1: cp = 21'($urandom_range(0, 'h7F));
			2:    cp = 21'($urandom_range('h80, 'h7FF));
			3: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				// move surrogates up into the range f800..ffff
				if (cp[15:11] == 5'b11011)
					cp[13] = 1'b1;
			end
			4:       cp = 21'($urandom_range('h10000, 'h10FFFF));
			default: cp = CP_EDGES[$urandom_range(0, 9)];
		endcase
		return cp;
	endfunction

	function automatic void put_bad();
		case ($urandom_range(0, 6))
			0: put_cp(21'($urandom_range(0, 'h7F)), 2);	// overlong forms
			1: put_cp(21'($urandom_range(0, 'h7FF)), 3);
			2: put_cp(21'($urandom_range(0, 'hFFFF)), 4);
			3: put_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
			4: put_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
			5: str_bytes.push_back(8'($urandom_range('h80, 'hBF)));
			default: str_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
		endcase
	endfunction

	// mostly well-formed strings, some broken, some pure noise
	function automatic void build_string();
		int          kind;
		logic [20:0] cp;
		str_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) begin
				cp = pick_cp();
				put_cp(cp, cp < 'h80 ? 1 : cp < 'h800 ? 2 : cp < 'h10000 ? 3 : 4);
			end
			if (kind >= 78) begin
				case (kind % 3)
					0: str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom);
					1: begin
						// cut a multi-byte sequence short at the end
						cp = 21'($urandom_range('h800, 'h10FFFF));
						put_cp(cp, cp < 'h10000 ? 3 : 4);
						repeat ($urandom_range(1, 2)) void'(str_bytes.pop_back());
					end
					default: begin
						put_bad();
						put_cp(21'($urandom_range(0, 'h7F)), 1);
					end
				endcase
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_words
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[31:16], m_axis_tdata[15:0], m_axis_tuser, m_axis_tlast};
			if (utf16_due.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing pending", m_axis_tdata));
			end else begin
				want = utf16_due.pop_front();
				if (got.unit !== want.unit)
					report_mismatch($sformatf("unit %h, want %h", got.unit, want.unit));
				if (got.unit_count !== want.unit_count)
					report_mismatch($sformatf("unit_count %0d, want %0d",
						got.unit_count, want.unit_count));
				if (got.is_error !== want.is_error)
					report_mismatch($sformatf("is_error %b, want %b", got.is_error, want.is_error));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %b, want %b", got.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : sink
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int str_no;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		foreach (DIR_ROWS[i])
			send_byte(DIR_ROWS[i].b, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		live_bytes = 0;
		str_no = 0;
		while (live_bytes < RANDOM_BYTES) begin
			build_string();
			str_no++;
			if (str_no == 20)
				hold_req = 1'b1;
			if (str_no % 37 == 5) begin
				// let the output drain completely before the next string
				s_axis_tvalid <= 1'b0;
				wait (utf16_due.size() == 0);
				@(posedge clk);
			end
			foreach (str_bytes[k])
				send_byte(str_bytes[k], k == str_bytes.size() - 1);
		end

		// last stretch runs without idle cycles on either side
		idle_on = 1'b0;
		while (live_bytes < RANDOM_BYTES + TAIL_BYTES) begin
			build_string();
			foreach (str_bytes[k])
				send_byte(str_bytes[k], k == str_bytes.size() - 1);
		end

		// a pair and a character, then a sequence truncated by the final byte
		send_byte(8'hF0, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE1, 1'b1);

		s_axis_tvalid <= 1'b0;
		wait (utf16_due.size() == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
